>>> hdl/kab_pkg.sv
// ----------------------------------------------------------------------------
// kab_pkg: shared types and constants for the angle and bias Kalman filter
// Fixed-point formats, register indexes, reset values, saturation helpers
// and the request and response bundles of the shared divider.
// ----------------------------------------------------------------------------
package kab_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int ANGLE_W   = 25;
	localparam int RATE_W    = 25;
	localparam int DT_W      = 17;
	localparam int NOISE_W   = 16;
	localparam int MNOISE_W  = 17;
	localparam int CFG_IDX_W = 2;

	// Multiplier operands hold a full word or an unsigned field with a sign bit.
	localparam int OPND_W = DATA_W + 1;
	localparam int PROD_W = 2 * OPND_W;
	// Divider: numerator is a word scaled by 2^FRAC_BITS, denominator one bit wider.
	localparam int NUM_W  = DATA_W + FRAC_BITS;
	localparam int DEN_W  = DATA_W + 1;

	typedef logic signed [DATA_W-1:0]  word_t;
	typedef logic signed [OPND_W-1:0]  opnd_t;
	typedef logic signed [PROD_W-1:0]  wide_t;
	typedef logic signed [DEN_W-1:0]   den_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [RATE_W-1:0]  rate_t;
	typedef logic [DT_W-1:0]           dt_t;
	typedef logic [NOISE_W-1:0]        noise_t;
	typedef logic [MNOISE_W-1:0]       mnoise_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam word_t FX_ONE   = DATA_W'(1 << FRAC_BITS);
	localparam wide_t FX_HALF  = PROD_W'(1 << (FRAC_BITS - 1));

	// Register indexes of the configuration port.
	localparam cfg_idx_t CFG_ANGLE_NOISE   = 2'd0;
	localparam cfg_idx_t CFG_BIAS_NOISE    = 2'd1;
	localparam cfg_idx_t CFG_MEASURE_NOISE = 2'd2;

	// Noise defaults 0.001, 0.003 and 0.03, rounded to the fixed-point grid.
	localparam noise_t  ANGLE_NOISE_RST   = NOISE_W'(int'(0.001 * real'(1 << FRAC_BITS)));
	localparam noise_t  BIAS_NOISE_RST    = NOISE_W'(int'(0.003 * real'(1 << FRAC_BITS)));
	localparam mnoise_t MEASURE_NOISE_RST = MNOISE_W'(int'(0.03 * real'(1 << FRAC_BITS)));

	typedef struct packed {
		logic  start;
		word_t num;
		den_t  den;
	} div_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		word_t quot;
	} div_rsp_t;

	function automatic wide_t ext_word(input word_t w);
		return {{(PROD_W-DATA_W){w[DATA_W-1]}}, w};
	endfunction

	function automatic word_t sat_word(input wide_t v);
		if (v[PROD_W-1:DATA_W-1] == '0 || v[PROD_W-1:DATA_W-1] == '1) begin
			return v[DATA_W-1:0];
		end
		return v[PROD_W-1] ? WORD_MIN : WORD_MAX;
	endfunction

	// Rounds a raw product to nearest with ties upward, then saturates.
	function automatic word_t fx_round(input wide_t p);
		wide_t r;
		r = (p + FX_HALF) >>> FRAC_BITS;
		return sat_word(r);
	endfunction

endpackage

>>> hdl/kab_if.sv
// ----------------------------------------------------------------------------
// kab_if: streaming channels of the angle and bias Kalman filter
// One channel carries sensor samples in, the other carries the estimates out.
// ----------------------------------------------------------------------------
interface kab_in_if import kab_pkg::*; ();
	logic   valid;
	logic   ready;
	angle_t measured_angle;
	rate_t  gyro_rate;
	dt_t    time_step;

	modport source (output valid, output measured_angle, output gyro_rate,
		output time_step, input ready);
	modport sink (input valid, input measured_angle, input gyro_rate,
		input time_step, output ready);
endinterface

interface kab_out_if import kab_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t filtered_angle;
	word_t estimated_bias;

	modport source (output valid, output filtered_angle, output estimated_bias,
		input ready);
	modport sink (input valid, input filtered_angle, input estimated_bias,
		output ready);
endinterface

>>> hdl/kalman_angle_bias_filter.sv
// Samples are taken one at a time: a new sample is accepted only after the result
// of the last one has been loaded into the output register. Each sample uses the
// shared divider, which forms both gains at one quotient bit per cycle, and the
// single shared multiplier, which forms ten products.
// Reset (arst_n low) restores the noise registers to 0.001, 0.003 and 0.03, zeroes
// angle and bias, sets the covariance to identity and empties the output register.
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter: two-state Kalman filter for angle and gyro bias
// Fuses an accelerometer angle with a bias-corrected gyro rate in signed
// fixed point and keeps a 2x2 error covariance between samples.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter import kab_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  cfg_idx_t      cfg_index,
	input  mnoise_t       cfg_data,
	kab_in_if.sink        sample,
	kab_out_if.source     result
);

	// Sequencer states. The block works on one sample at a time: it accepts a
	// transaction only in S_IDLE and returns there once the result has been
	// placed in the output register.
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_MUL     = 3'd1;
	localparam logic [2:0] S_WB      = 3'd2;
	localparam logic [2:0] S_K0_GO   = 3'd3;
	localparam logic [2:0] S_K0_WAIT = 3'd4;
	localparam logic [2:0] S_K1_GO   = 3'd5;
	localparam logic [2:0] S_K1_WAIT = 3'd6;
	localparam logic [2:0] S_OUT     = 3'd7;

	// Multiply steps. Each one runs the shared multiplier in S_MUL and writes
	// its rounded product back into the state in S_WB. The order of the
	// correction steps lets every covariance update see the old P00 and P01
	// without extra copies.
	localparam logic [3:0] ST_PRED_ANGLE = 4'd0;
	localparam logic [3:0] ST_PRED_CROSS = 4'd1;
	localparam logic [3:0] ST_PRED_P00   = 4'd2;
	localparam logic [3:0] ST_PRED_P11   = 4'd3;
	localparam logic [3:0] ST_CORR_ANGLE = 4'd4;
	localparam logic [3:0] ST_CORR_BIAS  = 4'd5;
	localparam logic [3:0] ST_CORR_P10   = 4'd6;
	localparam logic [3:0] ST_CORR_P00   = 4'd7;
	localparam logic [3:0] ST_CORR_P11   = 4'd8;
	localparam logic [3:0] ST_CORR_P01   = 4'd9;

	logic [2:0] state_q;
	logic [3:0] step_q;

	// Configuration registers.
	noise_t  an_q;
	noise_t  bn_q;
	mnoise_t mn_q;

	// Filter state.
	word_t ang_q;
	word_t bias_q;
	word_t p00_q;
	word_t p01_q;
	word_t p10_q;
	word_t p11_q;

	// Per-sample working registers.
	angle_t meas_q;
	dt_t    dt_q;
	word_t  rate_q;
	word_t  inner_q;
	word_t  k0_q;
	word_t  k1_q;
	word_t  y_q;
	wide_t  prod_q;

	// Output register.
	logic  out_valid_q;
	word_t out_ang_q;
	word_t out_bias_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	opnd_t op_a;
	opnd_t op_b;
	opnd_t dt_op;
	wide_t prod_nx;
	word_t t_w;
	word_t ang_add;
	word_t bias_add;
	word_t p00_add;
	word_t p00_sub;
	word_t p01_sub;
	word_t p10_sub;
	word_t p11_add;
	word_t p11_sub;
	word_t inner_nx;
	word_t rate_nx;
	word_t y_nx;
	den_t  s_den;
	logic  in_take;
	logic  out_load;

	assign in_take  = sample.valid && (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || result.ready);

	// The time step enters the multiplier as a positive operand.
	assign dt_op = $signed({{(OPND_W-DT_W){1'b0}}, dt_q});

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (step_q)
			ST_PRED_ANGLE: begin
				op_a = dt_op;
				op_b = {rate_q[DATA_W-1], rate_q};
			end
			ST_PRED_CROSS: begin
				op_a = dt_op;
				op_b = {p11_q[DATA_W-1], p11_q};
			end
			ST_PRED_P00: begin
				op_a = dt_op;
				op_b = {inner_q[DATA_W-1], inner_q};
			end
			ST_PRED_P11: begin
				op_a = $signed({{(OPND_W-NOISE_W){1'b0}}, bn_q});
				op_b = dt_op;
			end
			ST_CORR_ANGLE: begin
				op_a = {k0_q[DATA_W-1], k0_q};
				op_b = {y_q[DATA_W-1], y_q};
			end
			ST_CORR_BIAS: begin
				op_a = {k1_q[DATA_W-1], k1_q};
				op_b = {y_q[DATA_W-1], y_q};
			end
			ST_CORR_P10: begin
				op_a = {k1_q[DATA_W-1], k1_q};
				op_b = {p00_q[DATA_W-1], p00_q};
			end
			ST_CORR_P00: begin
				op_a = {k0_q[DATA_W-1], k0_q};
				op_b = {p00_q[DATA_W-1], p00_q};
			end
			ST_CORR_P11: begin
				op_a = {k1_q[DATA_W-1], k1_q};
				op_b = {p01_q[DATA_W-1], p01_q};
			end
			ST_CORR_P01: begin
				op_a = {k0_q[DATA_W-1], k0_q};
				op_b = {p01_q[DATA_W-1], p01_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_nx = op_a * op_b;
	assign t_w     = fx_round(prod_q);

	// Saturating updates that the write-back step picks from.
	assign ang_add  = sat_word(ext_word(ang_q) + ext_word(t_w));
	assign bias_add = sat_word(ext_word(bias_q) + ext_word(t_w));
	assign p00_add  = sat_word(ext_word(p00_q) + ext_word(t_w));
	assign p00_sub  = sat_word(ext_word(p00_q) - ext_word(t_w));
	assign p01_sub  = sat_word(ext_word(p01_q) - ext_word(t_w));
	assign p10_sub  = sat_word(ext_word(p10_q) - ext_word(t_w));
	assign p11_add  = sat_word(ext_word(p11_q) + ext_word(t_w));
	assign p11_sub  = sat_word(ext_word(p11_q) - ext_word(t_w));

	// The angle covariance growth term is summed exactly and saturated once.
	assign inner_nx = sat_word(ext_word(t_w) - ext_word(p01_q) - ext_word(p10_q)
		+ $signed({{(PROD_W-NOISE_W){1'b0}}, an_q}));

	assign rate_nx = sat_word($signed({{(PROD_W-RATE_W){sample.gyro_rate[RATE_W-1]}},
		sample.gyro_rate}) - ext_word(bias_q));

	assign y_nx = sat_word($signed({{(PROD_W-ANGLE_W){meas_q[ANGLE_W-1]}}, meas_q})
		- ext_word(ang_q));

	// Innovation variance, kept exact one bit wider than a word.
	assign s_den = $signed({p00_q[DATA_W-1], p00_q}) + $signed({1'b0, DATA_W'(mn_q)});

	// Both gains share the one divider: the angle gain first, then the bias gain.
	assign div_req.start = (state_q == S_K0_GO) || (state_q == S_K1_GO);
	assign div_req.num   = (state_q == S_K0_GO) ? p00_q : p10_q;
	assign div_req.den   = s_den;

	kab_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer, configuration and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_PRED_ANGLE;
			out_valid_q <= 1'b0;
			an_q        <= ANGLE_NOISE_RST;
			bn_q        <= BIAS_NOISE_RST;
			mn_q        <= MEASURE_NOISE_RST;
			ang_q       <= '0;
			bias_q      <= '0;
			p00_q       <= FX_ONE;
			p01_q       <= '0;
			p10_q       <= '0;
			p11_q       <= FX_ONE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ANGLE_NOISE:   an_q <= cfg_data[NOISE_W-1:0];
					CFG_BIAS_NOISE:    bn_q <= cfg_data[NOISE_W-1:0];
					CFG_MEASURE_NOISE: mn_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						step_q  <= ST_PRED_ANGLE;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_WB;
				end
				S_WB: begin
					unique case (step_q)
						ST_PRED_ANGLE: ang_q <= ang_add;
						ST_PRED_CROSS: begin
							p01_q <= p01_sub;
							p10_q <= p10_sub;
						end
						ST_PRED_P00:   p00_q  <= p00_add;
						ST_PRED_P11:   p11_q  <= p11_add;
						ST_CORR_ANGLE: ang_q  <= ang_add;
						ST_CORR_BIAS:  bias_q <= bias_add;
						ST_CORR_P10:   p10_q  <= p10_sub;
						ST_CORR_P00:   p00_q  <= p00_sub;
						ST_CORR_P11:   p11_q  <= p11_sub;
						ST_CORR_P01:   p01_q  <= p01_sub;
						default: ;
					endcase
					if (step_q == ST_PRED_P11) begin
						state_q <= S_K0_GO;
					end else if (step_q == ST_CORR_P01) begin
						state_q <= S_OUT;
					end else begin
						step_q  <= step_q + 4'd1;
						state_q <= S_MUL;
					end
				end
				S_K0_GO: begin
					state_q <= S_K0_WAIT;
				end
				S_K0_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_K1_GO;
					end
				end
				S_K1_GO: begin
					state_q <= S_K1_WAIT;
				end
				S_K1_WAIT: begin
					if (div_rsp.done) begin
						step_q  <= ST_CORR_ANGLE;
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and output data, which need no reset.
	always_ff @(posedge clk) begin
		if (in_take) begin
			meas_q <= sample.measured_angle;
			dt_q   <= sample.time_step;
			rate_q <= rate_nx;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_nx;
		end
		if (state_q == S_WB && step_q == ST_PRED_CROSS) begin
			inner_q <= inner_nx;
		end
		if (state_q == S_K0_GO) begin
			y_q <= y_nx;
		end
		if (state_q == S_K0_WAIT && div_rsp.done) begin
			k0_q <= div_rsp.quot;
		end
		if (state_q == S_K1_WAIT && div_rsp.done) begin
			k1_q <= div_rsp.quot;
		end
		if (out_load) begin
			out_ang_q  <= ang_q;
			out_bias_q <= bias_q;
		end
	end

	assign sample.ready          = (state_q == S_IDLE);
	assign result.valid          = out_valid_q;
	assign result.filtered_angle = out_ang_q;
	assign result.estimated_bias = out_bias_q;

`ifndef SYNTHESIS
	// The divider is only started when it has finished the previous gain.
	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// A finished quotient arrives only while the sequencer waits for it.
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_K0_WAIT || state_q == S_K1_WAIT))
		else $error("divider result arrived outside a wait state");

	// A new result appears only after the last correction step.
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result became valid outside the output state");

	// Without a sample transaction the block stays idle.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !sample.valid) |=> state_q == S_IDLE)
		else $error("sequencer left idle without a sample");

	// Multiply steps never run past the last covariance update.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_WB) |-> step_q <= ST_CORR_P01)
		else $error("multiply step out of range");
`endif

endmodule

>>> hdl/kab_div.sv
// ----------------------------------------------------------------------------
// kab_div: sequential fixed-point restoring divider on magnitudes
// Computes (num * 2^FRAC_BITS) / den truncated toward zero and saturated to
// a word, or 0 if den is 0, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kab_div import kab_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [NUM_W-1:0] MAG_LIM = NUM_W'(1) << (DATA_W - 1);
	localparam logic [NUM_W-1:0] MAG_MAX = MAG_LIM - NUM_W'(1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dmag_q;
	logic             neg_q;
	logic             zero_q;
	word_t            quot_q;

	logic [DATA_W-1:0] num_mag;
	logic [DEN_W-1:0]  den_mag;
	logic [DEN_W:0]    rem_sh;
	logic              fits;
	logic [DEN_W:0]    rem_nx;
	word_t             quot_nx;

	always_comb begin
		num_mag = req.num[DATA_W-1] ? DATA_W'(-req.num) : DATA_W'(req.num);
		den_mag = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
		rem_sh  = {rem_q, quo_q[NUM_W-1]};
		fits    = rem_sh >= {1'b0, dmag_q};
		rem_nx  = fits ? rem_sh - {1'b0, dmag_q} : rem_sh;
		if (zero_q) begin
			quot_nx = '0;
		end else if (neg_q) begin
			quot_nx = (quo_q > MAG_LIM) ? WORD_MIN : word_t'(-quo_q[DATA_W-1:0]);
		end else begin
			quot_nx = (quo_q > MAG_MAX) ? WORD_MAX : word_t'(quo_q[DATA_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= {num_mag, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			dmag_q <= den_mag;
			neg_q  <= req.num[DATA_W-1] ^ req.den[DEN_W-1];
			zero_q <= (req.den == '0);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				quo_q <= {quo_q[NUM_W-2:0], fits};
				rem_q <= rem_nx[DEN_W-1:0];
			end else begin
				quot_q <= quot_nx;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
